### src/dot_bracket_pair_matcher_core_defines.svh
// Assertion macros used by the top level of the bracket matcher RTL.
`ifndef DOT_BRACKET_PAIR_MATCHER_CORE_DEFINES_SVH
`define DOT_BRACKET_PAIR_MATCHER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define DBPM_ASSERT_ALWAYS(label, clock, rstn, expr, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (expr)) else $error(msg);
// Implication checked on every clock edge outside reset.
`define DBPM_ASSERT_IMPLY(label, clock, rstn, cond, expr, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (cond) |-> (expr)) \
		else $error(msg);
`else
`define DBPM_ASSERT_ALWAYS(label, clock, rstn, expr, msg)
`define DBPM_ASSERT_IMPLY(label, clock, rstn, cond, expr, msg)
`endif

`endif

### src/dbpm_pkg.sv
// Package with constants and types of the dot-bracket pair matcher.
`timescale 1ns / 1ps
package dbpm_pkg;

	localparam int SYMBOL_W        = 8;
	localparam int POS_OUT_W       = 12;
	localparam int MAX_LENGTH_DEF  = 4096;
	localparam int STACK_DEPTH_DEF = 2048;

	localparam logic [SYMBOL_W-1:0] SYM_OPEN  = 8'h28;
	localparam logic [SYMBOL_W-1:0] SYM_CLOSE = 8'h29;

	typedef enum logic [1:0] {
		ST_BALANCED        = 2'd0,
		ST_TOO_MANY_OPENS  = 2'd1,
		ST_TOO_MANY_CLOSES = 2'd2,
		ST_CAPACITY        = 2'd3
	} status_t;

	// Result of one character, minus the open position that comes from the stack memory.
	typedef struct packed {
		logic                 pair_valid;
		logic [POS_OUT_W-1:0] close_position;
		logic                 string_done;
		status_t              status;
	} result_t;

endpackage

### src/dbpm_stack_ram.sv
// Synchronous stack memory for pending open-bracket positions.
`timescale 1ns / 1ps
module dbpm_stack_ram
	import dbpm_pkg::*;
#(
	parameter int DEPTH = STACK_DEPTH_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int W     = POS_OUT_W
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### src/dbpm_ctrl.sv
// Per-character decision logic, string state and the first result stage.
`timescale 1ns / 1ps
module dbpm_ctrl
	import dbpm_pkg::*;
#(
	parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [SYMBOL_W-1:0]  symbol,
	input  logic                 last_symbol,
	input  logic                 s1_take,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output logic [POS_OUT_W-1:0] wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	output logic                 valid_s1,
	output result_t              res_s1
);

	localparam int PW = $clog2(MAX_LENGTH + 1);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [PW-1:0] POS_LIMIT   = PW'(MAX_LENGTH);
	localparam logic [DW-1:0] DEPTH_LIMIT = DW'(STACK_DEPTH);

	logic [PW-1:0] pos_q, pos_d;
	logic [DW-1:0] depth_q, depth_d;
	logic          failed_q, failed_d;
	logic          emit;
	result_t       res;
	logic [DW-1:0] depth_dec;

	assign depth_dec = depth_q - DW'(1);

	always_comb begin
		pos_d    = pos_q;
		depth_d  = depth_q;
		failed_d = failed_q;
		emit     = 1'b0;
		res      = '0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = AW'(depth_q);
		rd_addr  = AW'(depth_dec);
		wr_data  = POS_OUT_W'(pos_q);
		if (in_fire) begin
			if (failed_q) begin
				// The rest of a failed string is swallowed without results.
				if (last_symbol) begin
					pos_d    = '0;
					depth_d  = '0;
					failed_d = 1'b0;
				end
			end else if (pos_q >= POS_LIMIT) begin
				emit            = 1'b1;
				res.string_done = 1'b1;
				res.status      = ST_CAPACITY;
				failed_d        = 1'b1;
			end else begin
				pos_d = pos_q + PW'(1);
				case (symbol)
					SYM_OPEN: begin
						if (depth_q >= DEPTH_LIMIT) begin
							emit            = 1'b1;
							res.string_done = 1'b1;
							res.status      = ST_CAPACITY;
							failed_d        = 1'b1;
						end else begin
							wr_en   = 1'b1;
							depth_d = depth_q + DW'(1);
							if (last_symbol) begin
								emit            = 1'b1;
								res.string_done = 1'b1;
								res.status      = ST_TOO_MANY_OPENS;
							end
						end
					end
					SYM_CLOSE: begin
						emit = 1'b1;
						if (depth_q == '0) begin
							res.string_done = 1'b1;
							res.status      = ST_TOO_MANY_CLOSES;
							failed_d        = 1'b1;
						end else begin
							rd_en              = 1'b1;
							depth_d            = depth_dec;
							res.pair_valid     = 1'b1;
							res.close_position = POS_OUT_W'(pos_q);
							if (last_symbol) begin
								res.string_done = 1'b1;
								res.status      = (depth_dec == '0) ? ST_BALANCED
									: ST_TOO_MANY_OPENS;
							end
						end
					end
					default: begin
						if (last_symbol) begin
							emit            = 1'b1;
							res.string_done = 1'b1;
							res.status      = (depth_q == '0) ? ST_BALANCED
								: ST_TOO_MANY_OPENS;
						end
					end
				endcase
			end
			// The last character of a string always leaves clean state behind.
			if (last_symbol) begin
				pos_d    = '0;
				depth_d  = '0;
				failed_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			depth_q  <= '0;
			failed_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			pos_q    <= pos_d;
			depth_q  <= depth_d;
			failed_q <= failed_d;
			if (in_fire && emit) begin
				valid_s1 <= 1'b1;
			end else if (s1_take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			res_s1 <= res;
		end
	end

endmodule

### src/dbpm_out.sv
// Output register that joins the result stage with the stack read data.
`timescale 1ns / 1ps
module dbpm_out
	import dbpm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  result_t              res_s1,
	input  logic [POS_OUT_W-1:0] rd_data,
	output logic                 s1_take,
	output logic                 m_valid,
	input  logic                 m_ready,
	output result_t              res_out,
	output logic [POS_OUT_W-1:0] open_position
);

	logic out_valid_q;

	assign s1_take = valid_s1 && (!out_valid_q || m_ready);
	assign m_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			res_out       <= res_s1;
			open_position <= res_s1.pair_valid ? rd_data : '0;
		end
	end

endmodule

### src/dot_bracket_pair_matcher_core.sv
// Top level of the dot-bracket pair matcher.
//
//  channel  | side   | carries
//  ---------+--------+--------------------------------------------------------
//  s_axis   | input  | one structure character per transfer, tlast on the last
//  m_axis   | output | a pair, a final verdict, or both, tlast on the verdict
//
// One character is taken per cycle while s_axis_tready is high; results pass res_s1, then res_out.
// The open-bracket stack is one memory with at most one write or one read per character.
// Reset clears the string state at once; the stack memory needs no clearing.
// A stall on m_axis holds back s_axis only once both result registers are full.
`timescale 1ns / 1ps
`include "dot_bracket_pair_matcher_core_defines.svh"
module dot_bracket_pair_matcher_core
	import dbpm_pkg::*;
#(
	parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] symbol
	input  logic        s_axis_tlast,  // last_symbol
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [11:0] open_position, [23:12] close_position,
	                                   // [25:24] status, [31:26] zero
	output logic        m_axis_tuser,  // pair_valid
	output logic        m_axis_tlast   // string_done
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic                 in_fire;
	logic                 s1_take;
	logic                 wr_en, rd_en;
	logic [AW-1:0]        wr_addr, rd_addr;
	logic [POS_OUT_W-1:0] wr_data, rd_data;
	logic                 valid_s1;
	result_t              res_s1, res_out;
	logic [POS_OUT_W-1:0] open_position;

	assign s_axis_tready = !valid_s1 || s1_take;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	dbpm_ctrl #(
		.MAX_LENGTH  (MAX_LENGTH),
		.STACK_DEPTH (STACK_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.symbol      (s_axis_tdata),
		.last_symbol (s_axis_tlast),
		.s1_take     (s1_take),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.valid_s1    (valid_s1),
		.res_s1      (res_s1)
	);

	dbpm_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW),
		.W     (POS_OUT_W)
	) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dbpm_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.res_s1        (res_s1),
		.rd_data       (rd_data),
		.s1_take       (s1_take),
		.m_valid       (m_axis_tvalid),
		.m_ready       (m_axis_tready),
		.res_out       (res_out),
		.open_position (open_position)
	);

	assign m_axis_tdata = {6'd0, res_out.status, res_out.close_position, open_position};
	assign m_axis_tuser = res_out.pair_valid;
	assign m_axis_tlast = res_out.string_done;

	// A result without a pair carries zero positions.
	`DBPM_ASSERT_IMPLY(a_no_pair_zero_pos, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[23:0] == 24'd0, "positions set without a pair")
	// A status other than balanced only comes with a final verdict.
	`DBPM_ASSERT_IMPLY(a_status_needs_done, clk, arst_n, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[25:24] == 2'd0, "status set before string end")
	// The input is held back only when both result registers are occupied.
	`DBPM_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !s_axis_tready, valid_s1 && m_axis_tvalid && !m_axis_tready, "input stalled without a full pipeline")
	// The stack memory never sees a write and a read for the same character.
	`DBPM_ASSERT_ALWAYS(a_one_mem_op, clk, arst_n, !(wr_en && rd_en), "stack write and read together")

endmodule

### tb/bracket_match_checker.sv
// Checker that predicts and compares the results of the dot-bracket pair matcher.
`timescale 1ns / 1ps
module bracket_match_checker
	import dbpm_pkg::*;
#(
	parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] symbol
	input  logic        s_axis_tlast,  // last_symbol
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // [11:0] open_position, [23:12] close_position,
	                                   // [25:24] status, [31:26] zero
	input  logic        m_axis_tuser,  // pair_valid
	input  logic        m_axis_tlast,  // string_done
	output int          mismatch_count,
	output int          results_pending
);

	typedef struct packed {
		logic                 pair_valid;
		logic [POS_OUT_W-1:0] open_position;
		logic [POS_OUT_W-1:0] close_position;
		logic                 string_done;
		status_t              status;
	} match_t;

	match_t               expected_matches[$];
	logic [POS_OUT_W-1:0] open_positions[STACK_DEPTH];
	int                   open_depth;
	int                   char_position;
	bit                   string_aborted;

	function automatic void restart_string();
		open_depth     = 0;
		char_position  = 0;
		string_aborted = 1'b0;
	endfunction

	// Ends the string with an error verdict, or swallows the rest of it.
	function automatic void abort_string(input logic is_last);
		if (is_last)
			restart_string();
		else
			string_aborted = 1'b1;
	endfunction

	// Advances the matcher state by one character; returns 1 when a result is due.
	function automatic bit match_symbol(input logic [7:0] sym, input logic is_last,
	                                    output match_t res);
		int pos;
		res = '0;
		if (string_aborted) begin
			if (is_last)
				restart_string();
			return 1'b0;
		end
		pos = char_position;
		if (pos >= MAX_LENGTH) begin
			res.string_done = 1'b1;
			res.status      = ST_CAPACITY;
			abort_string(is_last);
			return 1'b1;
		end
		char_position = pos + 1;
		if (sym == SYM_OPEN) begin
			if (open_depth >= STACK_DEPTH) begin
				res.string_done = 1'b1;
				res.status      = ST_CAPACITY;
				abort_string(is_last);
				return 1'b1;
			end
			open_positions[open_depth] = pos[POS_OUT_W-1:0];
			open_depth++;
		end else if (sym == SYM_CLOSE) begin
			if (open_depth == 0) begin
				res.string_done = 1'b1;
				res.status      = ST_TOO_MANY_CLOSES;
				abort_string(is_last);
				return 1'b1;
			end
			open_depth--;
			res.pair_valid     = 1'b1;
			res.open_position  = open_positions[open_depth];
			res.close_position = pos[POS_OUT_W-1:0];
			if (is_last) begin
				res.string_done = 1'b1;
				res.status      = (open_depth == 0) ? ST_BALANCED : ST_TOO_MANY_OPENS;
				restart_string();
			end
			return 1'b1;
		end
		if (is_last) begin
			res.string_done = 1'b1;
			res.status      = (open_depth == 0) ? ST_BALANCED : ST_TOO_MANY_OPENS;
			restart_string();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
	                                    input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		match_t res;
		if (!arst_n) begin
			restart_string();
			expected_matches.delete();
			mismatch_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (match_symbol(s_axis_tdata, s_axis_tlast, res))
					expected_matches.push_back(res);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_matches.size() == 0) begin
					$error("result transfer with no result expected: tdata %0h", m_axis_tdata);
					mismatch_count++;
				end else begin
					res = expected_matches.pop_front();
					check_field("pair_valid", 32'(res.pair_valid), 32'(m_axis_tuser));
					check_field("open_position", 32'(res.open_position),
					            32'(m_axis_tdata[11:0]));
					check_field("close_position", 32'(res.close_position),
					            32'(m_axis_tdata[23:12]));
					check_field("string_done", 32'(res.string_done), 32'(m_axis_tlast));
					check_field("status", 32'(res.status), 32'(m_axis_tdata[25:24]));
					check_field("tdata padding", 32'd0, 32'(m_axis_tdata[31:26]));
				end
			end
		end
		results_pending = expected_matches.size();
	end

endmodule

### tb/testbench.sv
// Top of the dot-bracket pair matcher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench
	import dbpm_pkg::*;
();

	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_ITEMS    = 480;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	int mismatch_count;
	int results_pending;
	bit src_gaps_on  = 1'b1;
	bit hold_off_req = 1'b0;
	bit hold_off_done = 1'b0;

	always #6 clk = ~clk;

	dot_bracket_pair_matcher_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	bracket_match_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	// Mostly no gap or a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_char(input logic [7:0] sym, input logic is_last);
		int gap;
		gap = src_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= sym;
		s_axis_tlast  <= is_last;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_char(text[i], i == text.len() - 1);
	endtask

	// Any byte that is not a bracket.
	function automatic logic [7:0] filler_char();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == SYM_OPEN || c == SYM_CLOSE || $urandom_range(0, 1) == 0)
			c = ".";
		return c;
	endfunction

	// Random string, mostly balanced with random filler, sometimes arbitrary.
	task automatic build_string(output logic [7:0] chars[$]);
		int len;
		int depth;
		int r;
		bit well_formed;
		chars.delete();
		len         = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 30);
		well_formed = $urandom_range(0, 3) != 0;
		depth       = 0;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (!well_formed) begin
				if (r < 35)
					chars.push_back(SYM_OPEN);
				else if (r < 70)
					chars.push_back(SYM_CLOSE);
				else
					chars.push_back(filler_char());
			end else if (depth == len - i) begin
				chars.push_back(SYM_CLOSE);
				depth--;
			end else if (r < 40 && depth + 1 < len - i) begin
				chars.push_back(SYM_OPEN);
				depth++;
			end else if (r < 75 && depth > 0) begin
				chars.push_back(SYM_CLOSE);
				depth--;
			end else begin
				chars.push_back(filler_char());
			end
		end
	endtask

	// Receiver: random stalls, stretches of full rate, and one long hold-off.
	initial begin : sink_ready
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_off_req && !hold_off_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				stall = ($urandom_range(0, 4) == 0) ? 0 : pick_gap();
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		#100ms;
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] chars[$];
		int sent;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Short directed strings: plain, pairs, leftover opens, unmatched closes.
		send_text(".x");
		send_text("()");
		send_text("((");
		send_text("(()");
		send_text(")(.");
		send_text(")");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(SYM_OPEN, 1'b0);
		send_char(8'h00, 1'b0);
		send_char(SYM_CLOSE, 1'b0);
		send_char(8'hFF, 1'b1);

		// Random strings; the receiver takes its long hold-off early on.
		hold_off_req = 1'b1;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			build_string(chars);
			src_gaps_on = $urandom_range(0, 3) != 0;
			foreach (chars[i])
				send_char(chars[i], i == chars.size() - 1);
			sent += chars.size();
		end
		s_axis_tvalid <= 1'b0;

		// Let the checker record the final transfer before the count is read.
		@(posedge clk);
		wait (results_pending == 0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && results_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
